>>> src/remote_link_mode_controller_assert.svh
// Assertion macros used by the controller module to check its own logic.
`ifndef REMOTE_LINK_MODE_CONTROLLER_ASSERT_SVH
`define REMOTE_LINK_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RLMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlmc assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RLMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlmc assertion failed");

`endif

>>> src/rlmc_pkg.sv
`default_nettype none

package rlmc_pkg;

    localparam int ON_BIT          = 0;
    localparam int ALARM_BIT       = 1;
    localparam int LIGHTS_BIT      = 2;
    localparam int MODE_CHANGE_BIT = 3;
    localparam int IN_RANGE_BIT    = 4;

    localparam logic [2:0] M_INIT  = 3'd0;
    localparam logic [2:0] M_OFF   = 3'd1;
    localparam logic [2:0] M_RANGE = 3'd2;
    localparam logic [2:0] M_MOTOR = 3'd3;
    localparam logic [2:0] M_ALARM = 3'd4;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ON    = 2'd1;
    localparam logic [1:0] LED_FLASH = 2'd2;

    localparam logic [1:0] REG_SEND_INTERVAL = 2'd0;
    localparam logic [1:0] REG_THROTTLE_LOW  = 2'd1;
    localparam logic [1:0] REG_THROTTLE_HIGH = 2'd2;

    localparam logic [15:0] SEND_INTERVAL_RESET = 16'd10;
    localparam logic [15:0] THROTTLE_LOW_RESET  = 16'd0;
    localparam logic [15:0] THROTTLE_HIGH_RESET = 16'd5000;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] rem_init;
        logic [15:0] dividend_low;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> src/remote_link_mode_controller.sv
// A transaction without a throttle division has its result registered at acceptance and
// presented in the cycle after it. A send in motor-on that needs the division waits in the
// divide state for the 16 steps of the one-bit-per-cycle restoring divider, then presents it.
// Only one transaction is in flight at a time: no new one is taken until the result is taken,
// and the block accepts again in the cycle after that.
// Reset is asynchronous and active low; it restores the register defaults and the init mode.
`default_nettype none

`include "remote_link_mode_controller_assert.svh"

module remote_link_mode_controller
    import rlmc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        link_timeout,
    input  wire logic        packet_arrived,
    input  wire logic [7:0]  reply_status,
    input  wire logic        motor_button,
    input  wire logic        alarm_button,
    input  wire logic        lights_button,
    input  wire logic        light_mode_button,
    input  wire logic [15:0] throttle_mv,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       mode,
    output logic             send_now,
    output logic [7:0]       tx_status,
    output logic [15:0]      tx_throttle,
    output logic [1:0]       range_led,
    output logic [1:0]       alarm_led,
    output logic [1:0]       motor_led,
    output logic             throttle_sampling,
    output logic             radio_power,
    output logic             clear_mode_latch
);

    state_t      state_reg;
    logic [15:0] interval_reg;
    logic [15:0] low_reg;
    logic [15:0] high_reg;

    logic [2:0]  cur_reg;
    logic [2:0]  prev_reg;
    logic [7:0]  status_reg;
    logic [15:0] ticks_reg;
    logic [1:0]  range_led_reg;
    logic [1:0]  alarm_led_reg;
    logic [1:0]  motor_led_reg;
    logic        sampling_reg;
    logic        radio_reg;

    logic        send_reg;
    logic [7:0]  tx_status_reg;
    logic [15:0] tx_throttle_reg;
    logic        clr_reg;

    logic [2:0]  cur_next;
    logic [2:0]  prev_next;
    logic [7:0]  status_next;
    logic [15:0] ticks_next;
    logic [1:0]  range_led_next;
    logic [1:0]  alarm_led_next;
    logic [1:0]  motor_led_next;
    logic        sampling_next;
    logic        radio_next;
    logic        sent;
    logic        clr;
    logic        thr_send;
    logic        due;
    logic [15:0] ticks_inc;

    logic        thr_ok;
    logic        thr_ovf;
    logic [15:0] thr_diff;
    logic [15:0] thr_span;
    logic [31:0] thr_num;
    logic        accept;
    logic        need_div;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= SEND_INTERVAL_RESET;
            low_reg      <= THROTTLE_LOW_RESET;
            high_reg     <= THROTTLE_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SEND_INTERVAL: interval_reg <= cfg_data;
                REG_THROTTLE_LOW:  low_reg      <= cfg_data;
                REG_THROTTLE_HIGH: high_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        ticks_inc      = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
        due            = (ticks_inc >= interval_reg);
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        status_next    = status_reg;
        ticks_next     = ticks_inc;
        range_led_next = range_led_reg;
        alarm_led_next = alarm_led_reg;
        motor_led_next = motor_led_reg;
        sampling_next  = sampling_reg;
        radio_next     = radio_reg;
        sent           = 1'b0;
        clr            = 1'b0;
        thr_send       = 1'b0;

        case (cur_reg)
            M_OFF:
            begin
                if (prev_reg != M_OFF)
                begin
                    status_next[ON_BIT] = 1'b0;
                    prev_next           = M_OFF;
                end
                range_led_next = LED_FLASH;
                if (due)
                begin
                    sent       = 1'b1;
                    radio_next = 1'b1;
                    ticks_next = '0;
                end
                if (packet_arrived)
                begin
                    radio_next = 1'b0;
                    if (reply_status[IN_RANGE_BIT])
                    begin
                        cur_next       = M_RANGE;
                        range_led_next = LED_OFF;
                    end
                end
            end
            M_RANGE:
            begin
                if (prev_reg != M_RANGE)
                begin
                    range_led_next = LED_ON;
                    alarm_led_next = LED_OFF;
                    motor_led_next = LED_OFF;
                    prev_next      = M_RANGE;
                end
                if (link_timeout)
                begin
                    cur_next = M_OFF;
                end
                else
                begin
                    if (motor_button)
                        status_next[ON_BIT] = 1'b1;
                    else if (alarm_button)
                        status_next[ALARM_BIT] = 1'b1;
                    status_next[LIGHTS_BIT]      = lights_button;
                    status_next[MODE_CHANGE_BIT] = light_mode_button;
                    if (due)
                    begin
                        clr        = 1'b1;
                        sent       = 1'b1;
                        radio_next = 1'b1;
                        ticks_next = '0;
                    end
                    if (packet_arrived)
                    begin
                        radio_next = 1'b0;
                        if (reply_status[ON_BIT])
                        begin
                            cur_next       = M_MOTOR;
                            range_led_next = LED_OFF;
                        end
                        else if (reply_status[ALARM_BIT])
                        begin
                            cur_next = M_ALARM;
                        end
                    end
                end
            end
            M_MOTOR:
            begin
                if (prev_reg != M_MOTOR)
                begin
                    status_next[ON_BIT] = 1'b1;
                    motor_led_next      = LED_ON;
                    sampling_next       = 1'b1;
                    prev_next           = M_MOTOR;
                end
                if (link_timeout)
                begin
                    cur_next       = M_OFF;
                    motor_led_next = LED_OFF;
                    sampling_next  = 1'b0;
                end
                else
                begin
                    if (!motor_button)
                        status_next[ON_BIT] = 1'b0;
                    status_next[LIGHTS_BIT]      = lights_button;
                    status_next[MODE_CHANGE_BIT] = light_mode_button;
                    if (due)
                    begin
                        clr        = 1'b1;
                        sent       = 1'b1;
                        thr_send   = 1'b1;
                        radio_next = 1'b1;
                        ticks_next = '0;
                    end
                    if (packet_arrived)
                    begin
                        radio_next = 1'b0;
                        if (!reply_status[ON_BIT])
                        begin
                            cur_next      = M_RANGE;
                            sampling_next = 1'b0;
                        end
                    end
                end
            end
            M_ALARM:
            begin
                if (prev_reg != M_ALARM)
                begin
                    alarm_led_next = LED_ON;
                    prev_next      = M_ALARM;
                end
                status_next[ALARM_BIT]  = alarm_button;
                status_next[LIGHTS_BIT] = lights_button;
                if (due)
                begin
                    sent       = 1'b1;
                    radio_next = 1'b1;
                    ticks_next = '0;
                end
                if (packet_arrived)
                begin
                    radio_next = 1'b0;
                    if (!reply_status[ALARM_BIT])
                        cur_next = M_RANGE;
                end
            end
            default:
            begin
                cur_next = M_OFF;
            end
        endcase
    end

    // The quotient overflows 16 bits exactly when the upper half of the numerator
    // reaches the span; otherwise 16 restoring steps give the full quotient.
    always_comb
    begin
        thr_diff = throttle_mv - low_reg;
        thr_span = high_reg - low_reg;
        thr_num  = {thr_diff, 16'd0} - {16'd0, thr_diff};
        thr_ok   = (high_reg > low_reg) && (throttle_mv > low_reg);
        thr_ovf  = (thr_num[31:16] >= thr_span);
        need_div = thr_send && thr_ok && !thr_ovf;
    end

    assign div_req.start        = accept && need_div;
    assign div_req.rem_init     = thr_num[31:16];
    assign div_req.dividend_low = thr_num[15:0];
    assign div_req.divisor      = thr_span;

    rlmc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= M_INIT;
            prev_reg      <= M_INIT;
            status_reg    <= '0;
            ticks_reg     <= '0;
            range_led_reg <= LED_OFF;
            alarm_led_reg <= LED_OFF;
            motor_led_reg <= LED_OFF;
            sampling_reg  <= 1'b0;
            radio_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg       <= cur_next;
                        prev_reg      <= prev_next;
                        status_reg    <= status_next;
                        ticks_reg     <= ticks_next;
                        range_led_reg <= range_led_next;
                        alarm_led_reg <= alarm_led_next;
                        motor_led_reg <= motor_led_next;
                        sampling_reg  <= sampling_next;
                        radio_reg     <= radio_next;
                        state_reg     <= need_div ? S_DIV : S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The status byte is sampled after this transaction's button handling.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_reg        <= sent;
            tx_status_reg   <= sent ? status_next : 8'd0;
            clr_reg         <= clr;
            tx_throttle_reg <= (thr_send && thr_ok) ? 16'hFFFF : 16'd0;
        end
        else if ((state_reg == S_DIV) && div_rsp.done)
        begin
            tx_throttle_reg <= div_rsp.quotient;
        end
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = (state_reg == S_OUT);
    assign mode              = cur_reg;
    assign send_now          = send_reg;
    assign tx_status         = tx_status_reg;
    assign tx_throttle       = tx_throttle_reg;
    assign range_led         = range_led_reg;
    assign alarm_led         = alarm_led_reg;
    assign motor_led         = motor_led_reg;
    assign throttle_sampling = sampling_reg;
    assign radio_power       = radio_reg;
    assign clear_mode_latch  = clr_reg;

    `RLMC_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_reg == S_DIV)
    `RLMC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
    `RLMC_ASSERT_IMPL(a_throttle_needs_send, out_valid && (tx_throttle != 16'd0), send_now)
    `RLMC_ASSERT_IMPL(a_mode_in_range, 1'b1, cur_reg <= M_ALARM)

endmodule

`default_nettype wire

>>> src/rlmc_div.sv
`default_nettype none

module rlmc_div
    import rlmc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          rem_next;
    logic [15:0]          quo_reg;
    logic [15:0]          divisor_reg;
    logic [16:0]          trial;
    logic [16:0]          trial_diff;
    logic                 qbit;

    // One restoring step per cycle while busy; a remainder that starts below the divisor stays below it.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[15]};
        trial_diff = trial - {1'b0, divisor_reg};
        qbit       = (trial >= {1'b0, divisor_reg});
        rem_next   = qbit ? trial_diff[15:0] : trial[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            quo_reg     <= req.dividend_low;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[14:0], qbit};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> dv/remote_link_mode_controller_tb.sv
module remote_link_mode_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlmc_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 40;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_TICKS    = 100;

    typedef struct packed {
        logic        timeout;
        logic        packet;
        logic [7:0]  reply;
        logic        motor;
        logic        alarm;
        logic        lights;
        logic        lmode;
        logic [15:0] mv;
    } tick_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        send;
        logic [7:0]  status;
        logic [15:0] throttle;
        logic [1:0]  range_led;
        logic [1:0]  alarm_led;
        logic [1:0]  motor_led;
        logic        sampling;
        logic        radio;
        logic        clr;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        link_timeout;
    logic        packet_arrived;
    logic [7:0]  reply_status;
    logic        motor_button;
    logic        alarm_button;
    logic        lights_button;
    logic        light_mode_button;
    logic [15:0] throttle_mv;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  mode;
    logic        send_now;
    logic [7:0]  tx_status;
    logic [15:0] tx_throttle;
    logic [1:0]  range_led;
    logic [1:0]  alarm_led;
    logic [1:0]  motor_led;
    logic        throttle_sampling;
    logic        radio_power;
    logic        clear_mode_latch;

    // Predicted controller state and register copies.
    logic [15:0] cf_interval;
    logic [15:0] cf_low;
    logic [15:0] cf_high;
    logic [2:0]  pm_mode;
    logic [2:0]  pm_prev;
    logic [7:0]  pm_status;
    logic [15:0] pm_ticks;
    logic [1:0]  pm_range_led;
    logic [1:0]  pm_alarm_led;
    logic [1:0]  pm_motor_led;
    logic        pm_sampling;
    logic        pm_radio;

    report_t predicted_reports[$];

    bit tx_gaps;
    bit rx_gaps;
    int mismatch_count;
    int ticks_sent;
    int reports_checked;
    int sends_seen;
    int throttle_nonzero;
    int reg_writes;
    int mode_seen[8];

    remote_link_mode_controller u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .link_timeout      (link_timeout),
        .packet_arrived    (packet_arrived),
        .reply_status      (reply_status),
        .motor_button      (motor_button),
        .alarm_button      (alarm_button),
        .lights_button     (lights_button),
        .light_mode_button (light_mode_button),
        .throttle_mv       (throttle_mv),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .mode              (mode),
        .send_now          (send_now),
        .tx_status         (tx_status),
        .tx_throttle       (tx_throttle),
        .range_led         (range_led),
        .alarm_led         (alarm_led),
        .motor_led         (motor_led),
        .throttle_sampling (throttle_sampling),
        .radio_power       (radio_power),
        .clear_mode_latch  (clear_mode_latch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void reset_controller_model();
        cf_interval  = SEND_INTERVAL_RESET;
        cf_low       = THROTTLE_LOW_RESET;
        cf_high      = THROTTLE_HIGH_RESET;
        pm_mode      = M_INIT;
        pm_prev      = M_INIT;
        pm_status    = '0;
        pm_ticks     = '0;
        pm_range_led = LED_OFF;
        pm_alarm_led = LED_OFF;
        pm_motor_led = LED_OFF;
        pm_sampling  = 1'b0;
        pm_radio     = 1'b0;
    endfunction

    function automatic logic [15:0] scaled_throttle(input logic [15:0] mv);
        logic [31:0] span;
        logic [31:0] quotient;
        if (cf_high <= cf_low || mv <= cf_low)
            return 16'd0;
        span = 32'(cf_high - cf_low);
        quotient = (32'd65535 * 32'(mv - cf_low)) / span;
        return (quotient > 32'd65535) ? 16'hFFFF : quotient[15:0];
    endfunction

    function automatic report_t predict_link_report(input tick_t t);
        report_t r;
        logic    due;
        r = '0;
        if (pm_ticks != 16'hFFFF)
            pm_ticks = pm_ticks + 16'd1;
        due = (pm_ticks >= cf_interval);
        case (pm_mode)
            M_OFF:
            begin
                if (pm_prev != M_OFF)
                begin
                    pm_status[ON_BIT] = 1'b0;
                    pm_prev = M_OFF;
                end
                pm_range_led = LED_FLASH;
                if (due)
                begin
                    r.send = 1'b1;
                    r.status = pm_status;
                    pm_radio = 1'b1;
                    pm_ticks = '0;
                end
                if (t.packet)
                begin
                    pm_radio = 1'b0;
                    if (t.reply[IN_RANGE_BIT])
                    begin
                        pm_mode = M_RANGE;
                        pm_range_led = LED_OFF;
                    end
                end
            end
            M_RANGE:
            begin
                if (pm_prev != M_RANGE)
                begin
                    pm_range_led = LED_ON;
                    pm_alarm_led = LED_OFF;
                    pm_motor_led = LED_OFF;
                    pm_prev = M_RANGE;
                end
                if (t.timeout)
                    pm_mode = M_OFF;
                else
                begin
                    if (t.motor)
                        pm_status[ON_BIT] = 1'b1;
                    else if (t.alarm)
                        pm_status[ALARM_BIT] = 1'b1;
                    pm_status[LIGHTS_BIT] = t.lights;
                    pm_status[MODE_CHANGE_BIT] = t.lmode;
                    if (due)
                    begin
                        r.clr = 1'b1;
                        r.send = 1'b1;
                        r.status = pm_status;
                        pm_radio = 1'b1;
                        pm_ticks = '0;
                    end
                    if (t.packet)
                    begin
                        pm_radio = 1'b0;
                        if (t.reply[ON_BIT])
                        begin
                            pm_mode = M_MOTOR;
                            pm_range_led = LED_OFF;
                        end
                        else if (t.reply[ALARM_BIT])
                            pm_mode = M_ALARM;
                    end
                end
            end
            M_MOTOR:
            begin
                if (pm_prev != M_MOTOR)
                begin
                    pm_status[ON_BIT] = 1'b1;
                    pm_motor_led = LED_ON;
                    pm_sampling = 1'b1;
                    pm_prev = M_MOTOR;
                end
                if (t.timeout)
                begin
                    pm_mode = M_OFF;
                    pm_motor_led = LED_OFF;
                    pm_sampling = 1'b0;
                end
                else
                begin
                    if (!t.motor)
                        pm_status[ON_BIT] = 1'b0;
                    pm_status[LIGHTS_BIT] = t.lights;
                    pm_status[MODE_CHANGE_BIT] = t.lmode;
                    if (due)
                    begin
                        r.clr = 1'b1;
                        r.send = 1'b1;
                        r.status = pm_status;
                        r.throttle = scaled_throttle(t.mv);
                        pm_radio = 1'b1;
                        pm_ticks = '0;
                    end
                    if (t.packet)
                    begin
                        pm_radio = 1'b0;
                        if (!t.reply[ON_BIT])
                        begin
                            pm_mode = M_RANGE;
                            pm_sampling = 1'b0;
                        end
                    end
                end
            end
            M_ALARM:
            begin
                if (pm_prev != M_ALARM)
                begin
                    pm_alarm_led = LED_ON;
                    pm_prev = M_ALARM;
                end
                pm_status[ALARM_BIT] = t.alarm;
                pm_status[LIGHTS_BIT] = t.lights;
                if (due)
                begin
                    r.send = 1'b1;
                    r.status = pm_status;
                    pm_radio = 1'b1;
                    pm_ticks = '0;
                end
                if (t.packet)
                begin
                    pm_radio = 1'b0;
                    if (!t.reply[ALARM_BIT])
                        pm_mode = M_RANGE;
                end
            end
            default:
                pm_mode = M_OFF;
        endcase
        r.mode = pm_mode;
        r.range_led = pm_range_led;
        r.alarm_led = pm_alarm_led;
        r.motor_led = pm_motor_led;
        r.sampling = pm_sampling;
        r.radio = pm_radio;
        return r;
    endfunction

    function automatic tick_t mk_tick(input logic timeout, input logic packet,
                                      input logic [7:0] reply, input logic motor,
                                      input logic alarm, input logic lights,
                                      input logic lmode, input logic [15:0] mv);
        tick_t t;
        t.timeout = timeout;
        t.packet = packet;
        t.reply = reply;
        t.motor = motor;
        t.alarm = alarm;
        t.lights = lights;
        t.lmode = lmode;
        t.mv = mv;
        return t;
    endfunction

    function automatic logic [15:0] pick_mv();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return cf_low;
            3: return cf_low + 16'd1;
            4: return cf_high;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.timeout = ($urandom_range(0, 7) == 0);
        t.packet = 1'($urandom_range(0, 1));
        t.reply = 8'($urandom_range(0, 255));
        t.motor = 1'($urandom_range(0, 1));
        t.alarm = 1'($urandom_range(0, 1));
        t.lights = 1'($urandom_range(0, 1));
        t.lmode = 1'($urandom_range(0, 1));
        t.mv = pick_mv();
        return t;
    endfunction

    // Builds a tick whose reply, if one arrives, moves the controller toward the goal mode.
    function automatic tick_t steer_tick(input logic [2:0] goal);
        tick_t t;
        t = random_tick();
        t.timeout = 1'b0;
        case (pm_mode)
            M_OFF:
                t.reply[IN_RANGE_BIT] = (goal != M_OFF);
            M_RANGE:
            begin
                t.timeout = (goal == M_OFF);
                t.reply[ON_BIT] = (goal == M_MOTOR);
                t.reply[ALARM_BIT] = (goal == M_ALARM);
            end
            M_MOTOR:
            begin
                t.timeout = (goal == M_OFF);
                t.reply[ON_BIT] = (goal == M_MOTOR);
                if (goal == M_MOTOR)
                    t.motor = ($urandom_range(0, 3) != 0);
            end
            M_ALARM:
                t.reply[ALARM_BIT] = (goal == M_ALARM);
            default:
                t.packet = 1'b0;
        endcase
        return t;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_tick(input tick_t t);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        link_timeout      <= t.timeout;
        packet_arrived    <= t.packet;
        reply_status      <= t.reply;
        motor_button      <= t.motor;
        alarm_button      <= t.alarm;
        lights_button     <= t.lights;
        light_mode_button <= t.lmode;
        throttle_mv       <= t.mv;
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted_reports.push_back(predict_link_report(t));
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SEND_INTERVAL: cf_interval = value;
            REG_THROTTLE_LOW:  cf_low = value;
            REG_THROTTLE_HIGH: cf_high = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (predicted_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Reaches range mode at reset values, then walks each mode with a short send interval.
    task automatic test_mode_walk();
        int n;
        send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'hEF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        for (n = 0; n < 7; n++)
            send_tick(mk_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
        send_tick(mk_tick(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'h10, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        wait_drained();
        write_reg(REG_SEND_INTERVAL, 16'd2);
        send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'h02, 1'b0, 1'b1, 1'b0, 1'b0, 16'd100));
        send_tick(mk_tick(1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'hFD, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
        send_tick(mk_tick(1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'h10, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(1'b0, 1'b1, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
        send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 16'd2500));
        send_tick(mk_tick(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF));
        send_tick(mk_tick(1'b0, 1'b1, 8'hFE, 1'b1, 1'b0, 1'b0, 1'b0, 16'd3000));
        send_tick(mk_tick(1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        send_tick(mk_tick(1'b1, 1'b1, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 16'd4000));
    endtask

    // Sends a command every tick in motor-on and probes the throttle scaling edges.
    task automatic test_throttle_scaling();
        logic [15:0] lows[4];
        logic [15:0] highs[4];
        logic [15:0] probes[6];
        tick_t       t;
        int          s;
        int          p;
        int          tries;
        lows  = '{16'd0, 16'd1000, 16'd5000, 16'd6000};
        highs = '{16'hFFFF, 16'd5000, 16'd5000, 16'd5000};
        wait_drained();
        write_reg(REG_SEND_INTERVAL, 16'd1);
        for (s = 0; s < 4; s++)
        begin
            wait_drained();
            write_reg(REG_THROTTLE_LOW, lows[s]);
            write_reg(REG_THROTTLE_HIGH, highs[s]);
            tries = 0;
            while (pm_mode != M_MOTOR && tries < 12)
            begin
                t = steer_tick(M_MOTOR);
                t.packet = 1'b1;
                send_tick(t);
                tries++;
            end
            probes = '{16'd0, lows[s], lows[s] + 16'd1, highs[s] - 16'd1, highs[s], 16'hFFFF};
            for (p = 0; p < 6; p++)
            begin
                t = steer_tick(M_MOTOR);
                t.mv = probes[p];
                send_tick(t);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [2:0]  goals[5];
        logic [2:0]  goal;
        logic [15:0] ivl;
        logic [15:0] lo;
        logic [15:0] hi;
        int          phase;
        int          n;
        goals = '{M_OFF, M_RANGE, M_MOTOR, M_MOTOR, M_ALARM};
        goal = M_MOTOR;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ivl = 16'd1;
                    lo  = 16'd0;
                    hi  = 16'hFFFF;
                end
                1:
                begin
                    ivl = 16'd0;
                    lo  = 16'hFFFF;
                    hi  = 16'hFFFF;
                end
                2:
                begin
                    ivl = 16'hFFFF;
                    lo  = 16'hFFFF;
                    hi  = 16'd0;
                end
                default:
                begin
                    ivl = 16'($urandom_range(1, 6));
                    lo  = 16'($urandom_range(0, 3000));
                    if ($urandom_range(0, 4) == 0)
                        hi = 16'($urandom_range(0, lo));
                    else
                        hi = 16'($urandom_range(lo + 1, 65535));
                end
            endcase
            wait_drained();
            write_reg(REG_SEND_INTERVAL, ivl);
            write_reg(REG_THROTTLE_LOW, lo);
            write_reg(REG_THROTTLE_HIGH, hi);
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_gaps = ($urandom_range(0, 3) != 0);
                    rx_gaps = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 19) == 0)
                    goal = goals[$urandom_range(0, 4)];
                if (n == PHASE_TICKS / 2 || $urandom_range(0, 63) == 0)
                    pause_until_drained();
                if ($urandom_range(0, 9) < 7)
                    send_tick(steer_tick(goal));
                else
                    send_tick(random_tick());
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = rx_gaps ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : report_checker
        report_t want;
        report_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.mode     = mode;
            got.send     = send_now;
            got.status   = tx_status;
            got.throttle = tx_throttle;
            got.range_led = range_led;
            got.alarm_led = alarm_led;
            got.motor_led = motor_led;
            got.sampling = throttle_sampling;
            got.radio    = radio_power;
            got.clr      = clear_mode_latch;
            if (predicted_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("%0t: transaction with no prediction pending: expected none, actual %h",
                             $time, got);
            end
            else
            begin
                want = predicted_reports.pop_front();
                compare_field("mode", want.mode, got.mode);
                compare_field("send_now", want.send, got.send);
                compare_field("tx_status", want.status, got.status);
                compare_field("tx_throttle", want.throttle, got.throttle);
                compare_field("range_led", want.range_led, got.range_led);
                compare_field("alarm_led", want.alarm_led, got.alarm_led);
                compare_field("motor_led", want.motor_led, got.motor_led);
                compare_field("throttle_sampling", want.sampling, got.sampling);
                compare_field("radio_power", want.radio, got.radio);
                compare_field("clear_mode_latch", want.clr, got.clr);
                reports_checked++;
                mode_seen[want.mode]++;
                if (want.send)
                    sends_seen++;
                if (want.throttle != 16'd0)
                    throttle_nonzero++;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = REG_SEND_INTERVAL;
        cfg_data          = '0;
        in_valid          = 1'b0;
        link_timeout      = 1'b0;
        packet_arrived    = 1'b0;
        reply_status      = '0;
        motor_button      = 1'b0;
        alarm_button      = 1'b0;
        lights_button     = 1'b0;
        light_mode_button = 1'b0;
        throttle_mv       = '0;
        tx_gaps           = 1'b1;
        rx_gaps           = 1'b1;
        mismatch_count    = 0;
        ticks_sent        = 0;
        reports_checked   = 0;
        sends_seen        = 0;
        throttle_nonzero  = 0;
        reg_writes        = 0;
        reset_controller_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_mode_walk();
        test_throttle_scaling();
        test_random_traffic();
        wait_drained();

        $display("Ran %0d ticks across %0d register writes; %0d reports checked, %0d commands sent,",
                 ticks_sent, reg_writes, reports_checked, sends_seen);
        $display("%0d with nonzero throttle; reports in off %0d, in range %0d, motor %0d, alarm %0d.",
                 throttle_nonzero, mode_seen[M_OFF], mode_seen[M_RANGE], mode_seen[M_MOTOR],
                 mode_seen[M_ALARM]);
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
